// ===== rtl/core/twqg_pkg.sv =====
// Shared types, codes, constants and helpers of the tile window quad generator.
package twqg_pkg;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int MAP_ADDR_W = 14;
  localparam int TILE_W     = 8;
  localparam int SCROLL_W   = 16;
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 16;
  localparam int TEX_W      = 8;
  localparam int QUADS_W    = 10;
  localparam int DIM_W      = 8;
  localparam int ORIGIN_W   = 7;
  localparam int FINE_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Remainder unit: dividend up to 14 bits, divisor up to 2^14
  localparam int DIV_W     = 14;
  localparam int DIV_D_W   = DIV_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Map size limits
  localparam logic [DIM_W-1:0] DIM_MAX   = 8'd128;
  localparam logic [DIM_W-1:0] DIM_RESET = 8'd64;

  // Parameter defaults
  localparam int TILE_BITS_DEF      = 4;
  localparam int WIN_COLS_DEF       = 32;
  localparam int WIN_ROWS_DEF       = 16;
  localparam int MAP_ENTRIES_DEF    = 16384;
  localparam int ATLAS_COL_BITS_DEF = 3;

  // Quad corners, bit k belongs to vertex k of the two triangles
  localparam int                 VERTS     = 6;
  localparam logic [VERTS-1:0]   CORNER_X  = 6'b001110;
  localparam logic [VERTS-1:0]   CORNER_Y  = 6'b011100;
  localparam logic [2:0]         LAST_VERT = 3'd5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] RK_VERTEX = 2'd0;
  localparam logic [KIND_W-1:0] RK_SKIP   = 2'd1;
  localparam logic [KIND_W-1:0] RK_DONE   = 2'd2;

  // Register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [MAP_ADDR_W-1:0] map_addr;
    logic [TILE_W-1:0]     tile_value;
    logic [SCROLL_W-1:0]   scroll_x;
    logic [SCROLL_W-1:0]   scroll_y;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         result_kind;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
    logic                      last_of_cell;
    logic [QUADS_W-1:0]        quads_drawn;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_STEP,
    ST_ADDR,
    ST_DIV_ADDR,
    ST_TILE,
    ST_EMIT
  } state_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = 8'd1;
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

// ===== rtl/core/tile_window_quad_generator.sv =====
// Top level of the tile window quad generator: map store, sequencer and remainder unit.
//
// Holds a byte tile map of MAP_ENTRIES entries and turns a scrolled window of it into
// textured quads. A write transaction (command 0) stores one tile byte; the store has
// no reset, so every entry that a window touches must be written first. A start
// transaction (command 1) splits the pixel scroll into a coarse tile and a fine
// offset, backs up one tile where the coarse value is nonzero, and reduces both
// coarse values modulo the map size in one shared restoring remainder unit, one
// dividend bit per cycle, column first and then row; then the window is clipped and
// the block is ready again. A step transaction (command 2) visits the next window
// cell in row-major order: it forms the row product (8x8 multiply), then adds the
// column and issues the store read, then looks at the tile; when MAP_ENTRIES is not a
// power of two, the address goes through the remainder unit before the read. An empty
// tile gives one skip result; a nonzero tile gives six vertex results, one per cycle
// while out_ready is high, through a single output register. A step with no open
// window gives one finished result carrying the quad count. The block takes one
// input transaction at a time; a waiting result in the output register does not
// block acceptance of the next transaction. map_width and map_height sit on an
// APB-style port at byte addresses 0 and 4; the user must write them only while
// idle, and the block itself does not enforce it.
module tile_window_quad_generator #(
  parameter int TILE_BITS      = twqg_pkg::TILE_BITS_DEF,
  parameter int WIN_COLS       = twqg_pkg::WIN_COLS_DEF,
  parameter int WIN_ROWS       = twqg_pkg::WIN_ROWS_DEF,
  parameter int MAP_ENTRIES    = twqg_pkg::MAP_ENTRIES_DEF,
  parameter int ATLAS_COL_BITS = twqg_pkg::ATLAS_COL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  twqg_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output twqg_pkg::out_item_t                 out_data,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [twqg_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [twqg_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [twqg_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import twqg_pkg::*;

  localparam int AW       = $clog2(MAP_ENTRIES);
  localparam bit MAP_POW2 = (MAP_ENTRIES & (MAP_ENTRIES - 1)) == 0;
  localparam int CW       = $clog2(WIN_COLS);
  localparam int RW       = $clog2(WIN_ROWS);
  localparam int VCW      = $clog2(WIN_COLS + 1);
  localparam int VRW      = $clog2(WIN_ROWS + 1);
  localparam int CRS_W    = SCROLL_W - TILE_BITS;
  localparam logic [FINE_W-1:0] TSIZE      = FINE_W'(1 << TILE_BITS);
  localparam logic [TILE_W-1:0] ATLAS_MASK = TILE_W'((1 << ATLAS_COL_BITS) - 1);
  localparam logic [DIV_D_W-1:0] MAP_DEN   = DIV_D_W'(MAP_ENTRIES);

  // Tile map store, no reset
  logic [TILE_W-1:0] map_mem [MAP_ENTRIES];
  logic [TILE_W-1:0] rd_data_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_rd_addr;

  // Configuration
  logic [DIM_W-1:0] map_width_r, map_width_nxt;
  logic [DIM_W-1:0] map_height_r, map_height_nxt;
  logic             cfg_wr;

  // Sequencer and window state
  state_t              state_r, state_nxt;
  logic [ORIGIN_W-1:0] origin_col_r, origin_col_nxt;
  logic [ORIGIN_W-1:0] origin_row_r, origin_row_nxt;
  logic [FINE_W-1:0]   fine_x_r, fine_x_nxt;
  logic [FINE_W-1:0]   fine_y_r, fine_y_nxt;
  logic [CW-1:0]       cursor_col_r, cursor_col_nxt;
  logic [VRW-1:0]      cursor_row_r, cursor_row_nxt;
  logic [VCW-1:0]      visible_cols_r, visible_cols_nxt;
  logic [VRW-1:0]      visible_rows_r, visible_rows_nxt;
  logic [QUADS_W-1:0]  quad_count_r, quad_count_nxt;
  logic [DIM_W-1:0]    size_w_r, size_w_nxt;
  logic [DIM_W-1:0]    size_h_r, size_h_nxt;
  logic [DIV_W-1:0]    pend_row_r, pend_row_nxt;

  // Current cell
  logic [CW-1:0]       cell_col_r, cell_col_nxt;
  logic [RW-1:0]       cell_row_r, cell_row_nxt;
  logic [DIV_W-1:0]    prod_r, prod_nxt;
  logic [TILE_W-1:0]   t_r, t_nxt;
  logic [2:0]          vert_r, vert_nxt;

  // Shared remainder unit
  logic [DIV_W-1:0]     div_num_r, div_num_nxt;
  logic [DIV_D_W-1:0]   div_den_r, div_den_nxt;
  logic [DIV_D_W-1:0]   div_rem_r, div_rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [DIV_D_W-1:0]   div_shift;
  logic [DIV_D_W-1:0]   div_step;
  logic                 div_last;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_free;

  // Scratch
  logic                  in_acc;
  logic [CRS_W-1:0]      crs_x, crs_y;
  logic [FINE_W-1:0]     fin_x, fin_y;
  logic [DIM_W-1:0]      w_clamp, h_clamp;
  logic [DIM_W-1:0]      rem_span;
  logic [VCW-1:0]        col_inc;
  logic [DIM_W-1:0]      row_sum;
  logic [2*DIM_W-1:0]    row_prod;
  logic [DIV_W-1:0]      addr_sum;
  logic                  vx_bit, vy_bit;
  logic [CW:0]           vcol;
  logic [RW:0]           vrow;
  logic [COORD_W-1:0]    vx, vy;
  logic [TEX_W-1:0]      ucol, vtile;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration port: pready always high, decode on the word address bit
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAP_HEIGHT) ? CFG_DATA_W'(map_height_r)
                                                       : CFG_DATA_W'(map_width_r);

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MAP_WIDTH) map_width_nxt = cfg_pwdata[DIM_W-1:0];
      else map_height_nxt = cfg_pwdata[DIM_W-1:0];
    end
  end

  // One restoring step: shift in the next dividend bit, subtract where it fits
  assign div_shift = {div_rem_r[DIV_W-1:0], div_num_r[DIV_W-1]};
  assign div_step  = (div_shift >= div_den_r) ? div_shift - div_den_r : div_shift;
  assign div_last  = (div_cnt_r == DIV_CNT_W'(1));

  // Vertex arithmetic for the current corner
  assign vx_bit = CORNER_X[vert_r];
  assign vy_bit = CORNER_Y[vert_r];
  assign vcol   = {1'b0, cell_col_r} + (CW+1)'(vx_bit);
  assign vrow   = {1'b0, cell_row_r} + (RW+1)'(vy_bit);
  assign vx     = (COORD_W'(vcol) << TILE_BITS) - COORD_W'(fine_x_r);
  assign vy     = (COORD_W'(vrow) << TILE_BITS) - COORD_W'(fine_y_r);
  assign ucol   = (t_r & ATLAS_MASK) + TEX_W'(vx_bit);
  assign vtile  = (t_r >> ATLAS_COL_BITS) + TEX_W'(vy_bit);

  assign w_clamp  = clamp_size(map_width_r);
  assign h_clamp  = clamp_size(map_height_r);
  assign crs_x    = in_data.scroll_x[SCROLL_W-1:TILE_BITS];
  assign crs_y    = in_data.scroll_y[SCROLL_W-1:TILE_BITS];
  assign fin_x    = FINE_W'(in_data.scroll_x[TILE_BITS-1:0]);
  assign fin_y    = FINE_W'(in_data.scroll_y[TILE_BITS-1:0]);
  assign col_inc  = VCW'(cursor_col_r) + VCW'(1);
  assign row_sum  = DIM_W'(cell_row_nxt) + DIM_W'(origin_row_r);
  assign row_prod = row_sum * w_clamp;
  assign addr_sum = prod_r + DIV_W'(cell_col_r) + DIV_W'(origin_col_r);

  always_comb begin
    state_nxt        = state_r;
    origin_col_nxt   = origin_col_r;
    origin_row_nxt   = origin_row_r;
    fine_x_nxt       = fine_x_r;
    fine_y_nxt       = fine_y_r;
    cursor_col_nxt   = cursor_col_r;
    cursor_row_nxt   = cursor_row_r;
    visible_cols_nxt = visible_cols_r;
    visible_rows_nxt = visible_rows_r;
    quad_count_nxt   = quad_count_r;
    size_w_nxt       = size_w_r;
    size_h_nxt       = size_h_r;
    pend_row_nxt     = pend_row_r;
    cell_col_nxt     = cell_col_r;
    cell_row_nxt     = cell_row_r;
    prod_nxt         = prod_r;
    t_nxt            = t_r;
    vert_nxt         = vert_r;
    div_num_nxt      = div_num_r;
    div_den_nxt      = div_den_r;
    div_rem_nxt      = div_rem_r;
    div_cnt_nxt      = div_cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_rd_addr      = addr_sum[AW-1:0];
    rem_span         = '0;

    // Iterate the remainder unit while one of its states is active
    if (state_r == ST_DIV_COL || state_r == ST_DIV_ROW || state_r == ST_DIV_ADDR) begin
      div_num_nxt = div_num_r << 1;
      div_rem_nxt = div_step;
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_WRITE: begin
              mem_we = ({1'b0, in_data.map_addr} < (MAP_ADDR_W+1)'(MAP_ENTRIES));
            end
            CMD_START: begin
              // Back up one tile where the coarse value is nonzero
              fine_x_nxt   = fin_x;
              fine_y_nxt   = fin_y;
              div_num_nxt  = DIV_W'(crs_x);
              pend_row_nxt = DIV_W'(crs_y);
              if (crs_x != '0) begin
                div_num_nxt = DIV_W'(crs_x - CRS_W'(1));
                fine_x_nxt  = fin_x + TSIZE;
              end
              if (crs_y != '0) begin
                pend_row_nxt = DIV_W'(crs_y - CRS_W'(1));
                fine_y_nxt   = fin_y + TSIZE;
              end
              size_w_nxt     = w_clamp;
              size_h_nxt     = h_clamp;
              div_den_nxt    = DIV_D_W'(w_clamp);
              div_rem_nxt    = '0;
              div_cnt_nxt    = DIV_CNT_W'(DIV_W);
              cursor_col_nxt = '0;
              cursor_row_nxt = '0;
              quad_count_nxt = '0;
              state_nxt      = ST_DIV_COL;
            end
            CMD_STEP: begin
              state_nxt = ST_STEP;
            end
            default: begin
              // Undefined command: drop
            end
          endcase
        end
      end

      ST_DIV_COL: begin
        if (div_last) begin
          origin_col_nxt = div_step[ORIGIN_W-1:0];
          rem_span       = size_w_r - DIM_W'(div_step[ORIGIN_W-1:0]);
          visible_cols_nxt = (rem_span < DIM_W'(WIN_COLS)) ? rem_span[VCW-1:0]
                                                           : VCW'(WIN_COLS);
          div_num_nxt    = pend_row_r;
          div_den_nxt    = DIV_D_W'(size_h_r);
          div_rem_nxt    = '0;
          div_cnt_nxt    = DIV_CNT_W'(DIV_W);
          state_nxt      = ST_DIV_ROW;
        end
      end

      ST_DIV_ROW: begin
        if (div_last) begin
          origin_row_nxt = div_step[ORIGIN_W-1:0];
          rem_span       = size_h_r - DIM_W'(div_step[ORIGIN_W-1:0]);
          visible_rows_nxt = (rem_span < DIM_W'(WIN_ROWS)) ? rem_span[VRW-1:0]
                                                           : VRW'(WIN_ROWS);
          state_nxt      = ST_IDLE;
        end
      end

      ST_STEP: begin
        if (cursor_row_r >= visible_rows_r || VCW'(cursor_col_r) >= visible_cols_r) begin
          // No open window: report the quad count
          if (out_free) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt               = '0;
            out_data_nxt.result_kind   = RK_DONE;
            out_data_nxt.last_of_cell  = 1'b1;
            out_data_nxt.quads_drawn   = quad_count_r;
            state_nxt                  = ST_IDLE;
          end
        end else begin
          cell_col_nxt = cursor_col_r;
          cell_row_nxt = cursor_row_r[RW-1:0];
          prod_nxt     = row_prod[DIV_W-1:0];
          if (col_inc >= visible_cols_r) begin
            cursor_col_nxt = '0;
            cursor_row_nxt = cursor_row_r + VRW'(1);
          end else begin
            cursor_col_nxt = col_inc[CW-1:0];
          end
          state_nxt = ST_ADDR;
        end
      end

      ST_ADDR: begin
        if (MAP_POW2) begin
          mem_re    = 1'b1;
          state_nxt = ST_TILE;
        end else begin
          div_num_nxt = addr_sum;
          div_den_nxt = MAP_DEN;
          div_rem_nxt = '0;
          div_cnt_nxt = DIV_CNT_W'(DIV_W);
          state_nxt   = ST_DIV_ADDR;
        end
      end

      ST_DIV_ADDR: begin
        if (div_last) begin
          mem_re      = 1'b1;
          mem_rd_addr = div_step[AW-1:0];
          state_nxt   = ST_TILE;
        end
      end

      ST_TILE: begin
        if (rd_data_r == '0) begin
          if (out_free) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt              = '0;
            out_data_nxt.result_kind  = RK_SKIP;
            out_data_nxt.last_of_cell = 1'b1;
            state_nxt                 = ST_IDLE;
          end
        end else begin
          t_nxt     = rd_data_r - TILE_W'(1);
          vert_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_kind  = RK_VERTEX;
          out_data_nxt.vertex_x     = signed'(vx);
          out_data_nxt.vertex_y     = signed'(vy);
          out_data_nxt.tex_u        = ucol << TILE_BITS;
          out_data_nxt.tex_v        = vtile << TILE_BITS;
          out_data_nxt.last_of_cell = (vert_r == LAST_VERT);
          out_data_nxt.quads_drawn  = '0;
          if (vert_r == LAST_VERT) begin
            quad_count_nxt = quad_count_r + QUADS_W'(1);
            state_nxt      = ST_IDLE;
          end else begin
            vert_nxt = vert_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Map store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[in_data.map_addr[AW-1:0]] <= in_data.tile_value;
    if (mem_re) rd_data_r <= map_mem[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      map_width_r    <= DIM_RESET;
      map_height_r   <= DIM_RESET;
      origin_col_r   <= '0;
      origin_row_r   <= '0;
      fine_x_r       <= '0;
      fine_y_r       <= '0;
      cursor_col_r   <= '0;
      cursor_row_r   <= '0;
      visible_cols_r <= '0;
      visible_rows_r <= '0;
      quad_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      map_width_r    <= map_width_nxt;
      map_height_r   <= map_height_nxt;
      origin_col_r   <= origin_col_nxt;
      origin_row_r   <= origin_row_nxt;
      fine_x_r       <= fine_x_nxt;
      fine_y_r       <= fine_y_nxt;
      cursor_col_r   <= cursor_col_nxt;
      cursor_row_r   <= cursor_row_nxt;
      visible_cols_r <= visible_cols_nxt;
      visible_rows_r <= visible_rows_nxt;
      quad_count_r   <= quad_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload and datapath registers hold without reset
  always_ff @(posedge clk) begin
    size_w_r   <= size_w_nxt;
    size_h_r   <= size_h_nxt;
    pend_row_r <= pend_row_nxt;
    cell_col_r <= cell_col_nxt;
    cell_row_r <= cell_row_nxt;
    prod_r     <= prod_nxt;
    t_r        <= t_nxt;
    vert_r     <= vert_nxt;
    div_num_r  <= div_num_nxt;
    div_den_r  <= div_den_nxt;
    div_rem_r  <= div_rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/twqg_chk.sv =====
// Port-level checker for the tile window quad generator, bound to the top level.
module twqg_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input twqg_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input twqg_pkg::out_item_t             out_data,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [twqg_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [twqg_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [twqg_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input logic                            cfg_pready
);
  import twqg_pkg::*;

  // A step transaction leaves the sequencer busy in the cycle after it is accepted
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_STEP |=> !in_ready)
    else $error("in_ready high right after a step transaction");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Skip and finished results carry no vertex and close the cell
  a_non_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != RK_VERTEX |->
      out_data.vertex_x == '0 && out_data.vertex_y == '0 &&
      out_data.tex_u == '0 && out_data.tex_v == '0 && out_data.last_of_cell)
    else $error("non-vertex result with vertex fields set");

  // Vertex results carry no quad count
  a_vertex_quads: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RK_VERTEX |-> out_data.quads_drawn == '0)
    else $error("vertex result with quad count set");

endmodule

bind tile_window_quad_generator twqg_chk u_twqg_chk (.*);
